FILE: src/view_matrix_from_pose_assert.svh
// Assertion macros for the view matrix block.
// Included by the top level; no other dependencies.
`ifndef VIEW_MATRIX_FROM_POSE_ASSERT_SVH
`define VIEW_MATRIX_FROM_POSE_ASSERT_SVH
`ifndef SYNTHESIS
`define VMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("view matrix assertion failed");
`define VMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("view matrix assertion failed");
`else
`define VMP_ASSERT(lbl, clk, rst_n, prop)
`define VMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/vmp_pkg.sv
// Shared constants and types for the view matrix block.
// No dependencies.
package vmp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int AXIS_W        = 18;
  // the largest scaled magnitude of a nonzero vector lives in [2^29, 2^30)
  localparam int SCALE_W       = 30;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

FILE: src/vmp_if.sv
// Valid/ready channel interfaces for pose beats and matrix beats.
// Depends on vmp_pkg.
interface vmp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [vmp_pkg::WORD_W-1:0] pos_x;
  logic signed [vmp_pkg::WORD_W-1:0] pos_y;
  logic signed [vmp_pkg::WORD_W-1:0] pos_z;
  logic signed [vmp_pkg::WORD_W-1:0] dir_x;
  logic signed [vmp_pkg::WORD_W-1:0] dir_y;
  logic signed [vmp_pkg::WORD_W-1:0] dir_z;
  modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface vmp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vmp_pkg::AXIS_W-1:0] right_x;
  logic signed [vmp_pkg::AXIS_W-1:0] right_y;
  logic signed [vmp_pkg::AXIS_W-1:0] right_z;
  logic signed [vmp_pkg::AXIS_W-1:0] up_x;
  logic signed [vmp_pkg::AXIS_W-1:0] up_y;
  logic signed [vmp_pkg::AXIS_W-1:0] up_z;
  logic signed [vmp_pkg::AXIS_W-1:0] look_x;
  logic signed [vmp_pkg::AXIS_W-1:0] look_y;
  logic signed [vmp_pkg::AXIS_W-1:0] look_z;
  logic signed [vmp_pkg::WORD_W-1:0] trans_right;
  logic signed [vmp_pkg::WORD_W-1:0] trans_up;
  logic signed [vmp_pkg::WORD_W-1:0] trans_look;
  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  look_x, look_y, look_z, trans_right, trans_up, trans_look,
                  input ready);
  modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  look_x, look_y, look_z, trans_right, trans_up, trans_look,
                  output ready);
endinterface

FILE: src/vmp_norm3.sv
// Pipelined 3-vector normalizer: scale, square-sum, bit-per-stage isqrt,
// bit-per-stage divide. Carries a sideband word. Depends on vmp_pkg.
module vmp_norm3 #(
  parameter int IN_W      = 32,
  parameter int FRAC_BITS = vmp_pkg::FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vmp_pkg::pipe_ctl_t       ctl_i,
  input  logic signed [IN_W-1:0]   vec_i [3],
  input  logic [SB_W-1:0]          sb_i,
  output logic                     vld_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic [SB_W-1:0]          sb_o
);

  localparam int AXW   = FRAC_BITS + 2;
  localparam int MW    = vmp_pkg::SCALE_W;
  localparam int PW    = $clog2(IN_W);
  localparam int SHW   = $clog2(IN_W + MW);
  localparam int PRW   = 2 * MW;
  localparam int SQW   = 2 * MW + 2;
  localparam int SQ_N  = MW + 1;
  localparam int RMW   = MW + 2;
  localparam int NW    = MW + FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int DRW   = MW + 1;

  // ---- stage 1: magnitudes
  logic [IN_W-1:0] s1_a_r [3];
  logic [2:0]      s1_neg_r;
  logic [SB_W-1:0] s1_sb_r;
  logic            s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (ctl_i.en) s1_vld_r <= ctl_i.vld;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_r[i] <= vec_i[i][IN_W-1];
        s1_a_r[i]   <= vec_i[i][IN_W-1] ? $unsigned(-vec_i[i]) : $unsigned(vec_i[i]);
      end
      s1_sb_r <= sb_i;
    end
  end

  // ---- stage 2: max and leading one
  logic [IN_W-1:0] s2_m;
  logic [PW-1:0]   s2_p;

  always_comb begin
    s2_m = s1_a_r[0];
    if (s1_a_r[1] > s2_m) s2_m = s1_a_r[1];
    if (s1_a_r[2] > s2_m) s2_m = s1_a_r[2];
    s2_p = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (s2_m[b]) s2_p = PW'(b);
    end
  end

  logic [IN_W-1:0] s2_a_r [3];
  logic [2:0]      s2_neg_r;
  logic            s2_zero_r;
  logic            s2_dn_r;
  logic [SHW-1:0]  s2_amt_r;
  logic [SB_W-1:0] s2_sb_r;
  logic            s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (ctl_i.en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      s2_a_r    <= s1_a_r;
      s2_neg_r  <= s1_neg_r;
      s2_sb_r   <= s1_sb_r;
      s2_zero_r <= (s2_m == '0);
      s2_dn_r   <= SHW'(s2_p) > SHW'(MW - 1);
      s2_amt_r  <= (SHW'(s2_p) > SHW'(MW - 1)) ? SHW'(s2_p) - SHW'(MW - 1)
                                               : SHW'(MW - 1) - SHW'(s2_p);
    end
  end

  // ---- stage 3: common scale
  logic [MW-1:0]   s3_sc_r [3];
  logic [2:0]      s3_neg_r;
  logic            s3_zero_r;
  logic [SB_W-1:0] s3_sb_r;
  logic            s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (ctl_i.en) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        s3_sc_r[i] <= MW'(s2_dn_r ? (s2_a_r[i] >> s2_amt_r) : (s2_a_r[i] << s2_amt_r));
      end
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
      s3_sb_r   <= s2_sb_r;
    end
  end

  // ---- stage 4: squares
  logic [PRW-1:0]  s4_sq_r [3];
  logic [MW-1:0]   s4_sc_r [3];
  logic [2:0]      s4_neg_r;
  logic            s4_zero_r;
  logic [SB_W-1:0] s4_sb_r;
  logic            s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (ctl_i.en) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        s4_sq_r[i] <= PRW'(s3_sc_r[i]) * PRW'(s3_sc_r[i]);
      end
      s4_sc_r   <= s3_sc_r;
      s4_neg_r  <= s3_neg_r;
      s4_zero_r <= s3_zero_r;
      s4_sb_r   <= s3_sb_r;
    end
  end

  // ---- square root, one result bit per stage; index 0 holds the sum
  logic [SQW-1:0]  sq_sh_r   [SQ_N+1];
  logic [RMW-1:0]  sq_rem_r  [SQ_N+1];
  logic [SQ_N-1:0] sq_root_r [SQ_N+1];
  logic [MW-1:0]   sq_a_r    [SQ_N+1][3];
  logic [2:0]      sq_neg_r  [SQ_N+1];
  logic            sq_zero_r [SQ_N+1];
  logic [SB_W-1:0] sq_sb_r   [SQ_N+1];
  logic            sq_vld_r  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (ctl_i.en) sq_vld_r[0] <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      sq_sh_r[0]   <= SQW'(s4_sq_r[0]) + SQW'(s4_sq_r[1]) + SQW'(s4_sq_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_a_r[0]    <= s4_sc_r;
      sq_neg_r[0]  <= s4_neg_r;
      sq_zero_r[0] <= s4_zero_r;
      sq_sb_r[0]   <= s4_sb_r;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [RMW+1:0] rem_t;
    logic [RMW+1:0] trial;
    logic           ge;

    always_comb begin
      rem_t = {sq_rem_r[j], sq_sh_r[j][SQW-1 -: 2]};
      trial = {1'b0, sq_root_r[j], 2'b01};
      ge    = rem_t >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[j+1] <= 1'b0;
      else if (ctl_i.en) sq_vld_r[j+1] <= sq_vld_r[j];
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        sq_rem_r[j+1]  <= ge ? RMW'(rem_t - trial) : RMW'(rem_t);
        sq_root_r[j+1] <= {sq_root_r[j][SQ_N-2:0], ge};
        sq_sh_r[j+1]   <= sq_sh_r[j] << 2;
        sq_a_r[j+1]    <= sq_a_r[j];
        sq_neg_r[j+1]  <= sq_neg_r[j];
        sq_zero_r[j+1] <= sq_zero_r[j];
        sq_sb_r[j+1]   <= sq_sb_r[j];
      end
    end
  end

  // ---- divide (|c| << F + n/2) / n, one quotient bit per stage
  logic [DRW-1:0]  dv_r_r    [QW+1][3];
  logic [QW-1:0]   dv_lo_r   [QW+1][3];
  logic [QW-1:0]   dv_q_r    [QW+1][3];
  logic [SQ_N-1:0] dv_n_r    [QW+1];
  logic [2:0]      dv_neg_r  [QW+1];
  logic            dv_zero_r [QW+1];
  logic [SB_W-1:0] dv_sb_r   [QW+1];
  logic            dv_vld_r  [QW+1];
  logic [NW-1:0]   dv_num    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[i] = (NW'(sq_a_r[SQ_N][i]) << FRAC_BITS) + NW'(sq_root_r[SQ_N] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (ctl_i.en) dv_vld_r[0] <= sq_vld_r[SQ_N];
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r_r[0][i]  <= DRW'(dv_num[i] >> QW);
        dv_lo_r[0][i] <= dv_num[i][QW-1:0];
        dv_q_r[0][i]  <= '0;
      end
      dv_n_r[0]    <= sq_root_r[SQ_N];
      dv_neg_r[0]  <= sq_neg_r[SQ_N];
      dv_zero_r[0] <= sq_zero_r[SQ_N];
      dv_sb_r[0]   <= sq_sb_r[SQ_N];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DRW:0] r2 [3];
    logic [2:0]   ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {dv_r_r[j][i], dv_lo_r[j][i][QW-1]};
        ge[i] = r2[i] >= (DRW+1)'(dv_n_r[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j+1] <= 1'b0;
      else if (ctl_i.en) dv_vld_r[j+1] <= dv_vld_r[j];
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        for (int i = 0; i < 3; i++) begin
          dv_r_r[j+1][i]  <= ge[i] ? DRW'(r2[i] - (DRW+1)'(dv_n_r[j])) : DRW'(r2[i]);
          dv_lo_r[j+1][i] <= dv_lo_r[j][i] << 1;
          dv_q_r[j+1][i]  <= {dv_q_r[j][i][QW-2:0], ge[i]};
        end
        dv_n_r[j+1]    <= dv_n_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
        dv_sb_r[j+1]   <= dv_sb_r[j];
      end
    end
  end

  // ---- clamp to one, restore sign
  localparam logic [QW-1:0] UNIT = QW'(1) << FRAC_BITS;

  logic [QW-1:0]           qc [3];
  logic signed [AXW-1:0]   unit_r [3];
  logic [SB_W-1:0]         sb_r;
  logic                    vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q_r[QW][i] > UNIT) ? UNIT : dv_q_r[QW][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (ctl_i.en) vld_r <= dv_vld_r[QW];
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[QW]) unit_r[i] <= '0;
        else if (dv_neg_r[QW][i]) unit_r[i] <= -$signed(AXW'(qc[i]));
        else unit_r[i] <= $signed(AXW'(qc[i]));
      end
      sb_r <= dv_sb_r[QW];
    end
  end

  assign vld_o  = vld_r;
  assign unit_o = unit_r;
  assign sb_o   = sb_r;

endmodule

FILE: src/view_matrix_from_pose.sv
// channel | dir | beat contents
// in_ch   | in  | pos_x/y/z, dir_x/y/z (Q16.16 words)
// out_ch  | out | right/up/look x/y/z (18b), trans_right/up/look (32b)
//
// One beat accepted per cycle while the output is not stalled; the pipeline
// holds two normalizer passes, each a 31-stage isqrt and FRAC_BITS+1 divide.
// Synchronous active-low reset clears only the valid bits.
// Whole pipeline advances together; a stalled output freezes every stage,
// so in_ch.ready follows the output register.
// Top level: look-at view basis. Depends on vmp_pkg, vmp_if, vmp_norm3 and
// view_matrix_from_pose_assert.svh.
`include "view_matrix_from_pose_assert.svh"
module view_matrix_from_pose #(
  parameter int FRAC_BITS = vmp_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vmp_in_if.sink    in_ch,
  vmp_out_if.source out_ch
);

  localparam int WW  = vmp_pkg::WORD_W;
  localparam int AXW = FRAC_BITS + 2;
  localparam int RRW = WW + 1;
  localparam int PRW = AXW + RRW;
  localparam int CW  = PRW + 1;
  localparam int TPW = WW + AXW;
  localparam int VW  = TPW + 3;
  localparam int CSB = 3 * WW + 6 * AXW;

  localparam logic signed [VW-1:0] TMAX = {{(VW-WW+1){1'b0}}, {(WW-1){1'b1}}};
  localparam logic signed [VW-1:0] TMIN = {{(VW-WW+1){1'b1}}, {(WW-1){1'b0}}};

  logic en;
  logic out_vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- T1: input register
  logic signed [WW-1:0] t1_p_r [3];
  logic signed [WW-1:0] t1_d_r [3];
  logic                 t1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t1_vld_r <= 1'b0;
    else if (en) t1_vld_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_p_r[0] <= in_ch.pos_x;
      t1_p_r[1] <= in_ch.pos_y;
      t1_p_r[2] <= in_ch.pos_z;
      t1_d_r[0] <= in_ch.dir_x;
      t1_d_r[1] <= in_ch.dir_y;
      t1_d_r[2] <= in_ch.dir_z;
    end
  end

  // ---- look and right normalizers run side by side
  logic signed [RRW-1:0] rr_vec [3];
  vmp_pkg::pipe_ctl_t    ctl_a;

  always_comb begin
    rr_vec[0] = RRW'(t1_d_r[2]);
    rr_vec[1] = '0;
    rr_vec[2] = -RRW'(t1_d_r[0]);
  end

  assign ctl_a = '{en: en, vld: t1_vld_r};

  logic signed [AXW-1:0] look_a [3];
  logic signed [AXW-1:0] right_a [3];
  logic [2*RRW-1:0]      lk_sb;
  logic [3*WW-1:0]       rt_sb;
  logic                  lk_vld;
  logic                  rt_vld;

  vmp_norm3 #(.IN_W(WW), .FRAC_BITS(FRAC_BITS), .SB_W(2*RRW)) u_look (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_a), .vec_i(t1_d_r),
    .sb_i({rr_vec[0], rr_vec[2]}), .vld_o(lk_vld), .unit_o(look_a), .sb_o(lk_sb)
  );

  vmp_norm3 #(.IN_W(RRW), .FRAC_BITS(FRAC_BITS), .SB_W(3*WW)) u_right (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_a), .vec_i(rr_vec),
    .sb_i({t1_p_r[0], t1_p_r[1], t1_p_r[2]}), .vld_o(rt_vld), .unit_o(right_a),
    .sb_o(rt_sb)
  );

  logic signed [RRW-1:0] a_rx;
  logic signed [RRW-1:0] a_rz;
  logic signed [WW-1:0]  a_p [3];

  assign a_rx = lk_sb[2*RRW-1:RRW];
  assign a_rz = lk_sb[RRW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) a_p[i] = rt_sb[(2-i)*WW +: WW];
  end

  // ---- T2: cross product terms (rraw.y is zero)
  logic signed [PRW-1:0] t2_c_r [4];
  logic signed [AXW-1:0] t2_look_r [3];
  logic signed [AXW-1:0] t2_right_r [3];
  logic signed [WW-1:0]  t2_p_r [3];
  logic                  t2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t2_vld_r <= 1'b0;
    else if (en) t2_vld_r <= lk_vld && rt_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_c_r[0]  <= look_a[1] * a_rz;
      t2_c_r[1]  <= look_a[2] * a_rx;
      t2_c_r[2]  <= look_a[0] * a_rz;
      t2_c_r[3]  <= look_a[1] * a_rx;
      t2_look_r  <= look_a;
      t2_right_r <= right_a;
      t2_p_r     <= a_p;
    end
  end

  // ---- T3: cross product
  logic signed [CW-1:0]  t3_craw_r [3];
  logic signed [AXW-1:0] t3_look_r [3];
  logic signed [AXW-1:0] t3_right_r [3];
  logic signed [WW-1:0]  t3_p_r [3];
  logic                  t3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t3_vld_r <= 1'b0;
    else if (en) t3_vld_r <= t2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_craw_r[0] <= CW'(t2_c_r[0]);
      t3_craw_r[1] <= CW'(t2_c_r[1]) - CW'(t2_c_r[2]);
      t3_craw_r[2] <= -CW'(t2_c_r[3]);
      t3_look_r    <= t2_look_r;
      t3_right_r   <= t2_right_r;
      t3_p_r       <= t2_p_r;
    end
  end

  // ---- up normalizer
  vmp_pkg::pipe_ctl_t    ctl_c;
  logic signed [AXW-1:0] up_c [3];
  logic [CSB-1:0]        c_sb;
  logic                  c_vld;

  assign ctl_c = '{en: en, vld: t3_vld_r};

  vmp_norm3 #(.IN_W(CW), .FRAC_BITS(FRAC_BITS), .SB_W(CSB)) u_up (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_c), .vec_i(t3_craw_r),
    .sb_i({t3_p_r[0], t3_p_r[1], t3_p_r[2],
           t3_look_r[0], t3_look_r[1], t3_look_r[2],
           t3_right_r[0], t3_right_r[1], t3_right_r[2]}),
    .vld_o(c_vld), .unit_o(up_c), .sb_o(c_sb)
  );

  logic signed [WW-1:0]  c_p [3];
  logic signed [AXW-1:0] c_ax [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_ax[0][i] = c_sb[(2-i)*AXW +: AXW];
      c_ax[1][i] = up_c[i];
      c_ax[2][i] = c_sb[(5-i)*AXW +: AXW];
      c_p[i]     = c_sb[6*AXW + (2-i)*WW +: WW];
    end
  end

  // ---- T4: position times axes; index 0 right, 1 up, 2 look
  logic signed [TPW-1:0] t4_prod_r [3][3];
  logic signed [AXW-1:0] t4_ax_r [3][3];
  logic                  t4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t4_vld_r <= 1'b0;
    else if (en) t4_vld_r <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          t4_prod_r[k][i] <= c_p[i] * c_ax[k][i];
        end
      end
      t4_ax_r <= c_ax;
    end
  end

  // ---- T5: negated dot plus half LSB
  logic signed [VW-1:0]  t5_v_r [3];
  logic signed [AXW-1:0] t5_ax_r [3][3];
  logic                  t5_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t5_vld_r <= 1'b0;
    else if (en) t5_vld_r <= t4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t5_v_r[k] <= (VW'(1) << (FRAC_BITS - 1)) - VW'(t4_prod_r[k][0])
                     - VW'(t4_prod_r[k][1]) - VW'(t4_prod_r[k][2]);
      end
      t5_ax_r <= t4_ax_r;
    end
  end

  // ---- output register: floor shift and saturate
  logic signed [VW-1:0]  sh_v [3];
  logic signed [WW-1:0]  out_trans_r [3];
  logic signed [AXW-1:0] out_ax_r [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) sh_v[k] = t5_v_r[k] >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= t5_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (sh_v[k] > TMAX) out_trans_r[k] <= TMAX[WW-1:0];
        else if (sh_v[k] < TMIN) out_trans_r[k] <= TMIN[WW-1:0];
        else out_trans_r[k] <= sh_v[k][WW-1:0];
      end
      out_ax_r <= t5_ax_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.right_x     = vmp_pkg::AXIS_W'(out_ax_r[0][0]);
  assign out_ch.right_y     = vmp_pkg::AXIS_W'(out_ax_r[0][1]);
  assign out_ch.right_z     = vmp_pkg::AXIS_W'(out_ax_r[0][2]);
  assign out_ch.up_x        = vmp_pkg::AXIS_W'(out_ax_r[1][0]);
  assign out_ch.up_y        = vmp_pkg::AXIS_W'(out_ax_r[1][1]);
  assign out_ch.up_z        = vmp_pkg::AXIS_W'(out_ax_r[1][2]);
  assign out_ch.look_x      = vmp_pkg::AXIS_W'(out_ax_r[2][0]);
  assign out_ch.look_y      = vmp_pkg::AXIS_W'(out_ax_r[2][1]);
  assign out_ch.look_z      = vmp_pkg::AXIS_W'(out_ax_r[2][2]);
  assign out_ch.trans_right = out_trans_r[0];
  assign out_ch.trans_up    = out_trans_r[1];
  assign out_ch.trans_look  = out_trans_r[2];

  // zero look means zero direction, so every axis is zero
  `VMP_ASSERT(a_look_zero_axes, clk, rst_n, out_vld_r && out_ax_r[2][0] == 0 && out_ax_r[2][1] == 0 && out_ax_r[2][2] == 0 |-> out_ax_r[0][0] == 0 && out_ax_r[0][2] == 0 && out_ax_r[1][0] == 0 && out_ax_r[1][1] == 0 && out_ax_r[1][2] == 0)
  // direction along world up leaves no right axis, hence no up axis
  `VMP_ASSERT(a_right_zero_up, clk, rst_n, out_vld_r && out_ax_r[0][0] == 0 && out_ax_r[0][1] == 0 && out_ax_r[0][2] == 0 |-> out_ax_r[1][0] == 0 && out_ax_r[1][1] == 0 && out_ax_r[1][2] == 0)
  `VMP_ASSERT(a_look_zero_trans, clk, rst_n, out_vld_r && out_ax_r[2][0] == 0 && out_ax_r[2][1] == 0 && out_ax_r[2][2] == 0 |-> out_trans_r[0] == 0 && out_trans_r[1] == 0 && out_trans_r[2] == 0)
  `VMP_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en && t2_vld_r, t2_vld_r && $stable(t2_c_r[0]) && $stable(t2_c_r[3]))

endmodule
